// ----- design/dds_pkg.sv -----
package dds_pkg;

   localparam int FreqWidth      = 32;
   localparam int WordWidth      = 32;
   localparam int CtrlWidth      = 8;
   localparam int FrameBits      = WordWidth + CtrlWidth;
   localparam int IndexWidth     = 6;
   localparam int RecipShift     = 56;
   localparam int WordLsb        = RecipShift - WordWidth;
   localparam int ProductWidth   = FreqWidth + WordWidth;
   localparam int CsrIndexWidth  = 8;
   localparam int CsrDataWidth   = 32;

   localparam logic [CtrlWidth-1:0] CtrlMultiplier = 8'h01;
   localparam logic [CtrlWidth-1:0] CtrlPowerDown  = 8'h04;
   localparam logic [CtrlWidth-1:0] CtrlNone       = 8'h00;
   localparam logic [CtrlWidth-1:0] ByteMask       = 8'hFF;

   localparam logic [WordWidth-1:0] ReciprocalReset = 32'd400319966;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_RECIPROCAL    = 8'd0,
      CSR_MULTIPLIER_ON = 8'd1,
      CSR_POWERED_DOWN  = 8'd2,
      CSR_INVERT_LINES  = 8'd3
   } csr_index_type;

   function automatic logic [CtrlWidth-1:0] control_byte(input logic powered_down,
                                                         input logic multiplier_on);
      logic [CtrlWidth-1:0] ctrl;
      if (powered_down) begin
         ctrl = CtrlPowerDown;
      end else if (multiplier_on) begin
         ctrl = CtrlMultiplier;
      end else begin
         ctrl = CtrlNone;
      end
      return ctrl & ByteMask;
   endfunction

endpackage

// ----- design/dds_tuning_word_serial_loader.sv -----
// The first bit of a frame is offered once its item has moved through the input,
// multiply and frame registers in turn. One frame bit goes out per cycle while
// rsp_ready is high; the bit serializer at the output sets the item rate, while
// two more items can wait in the input and multiply registers.
// Reset: synchronous, active high; clears all valid flags and loads the
// register defaults (reciprocal 400319966, multiplier on, inverted lines).
module dds_tuning_word_serial_loader (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [dds_pkg::FreqWidth-1:0]        req_freq_hz,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_line_level,
   output logic [dds_pkg::IndexWidth-1:0]       rsp_bit_index,
   output logic [dds_pkg::WordWidth-1:0]        rsp_tuning_word,
   output logic                                 rsp_latch,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dds_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [dds_pkg::CsrDataWidth-1:0]     csr_data
);
   import dds_pkg::*;

   localparam logic [IndexWidth-1:0] LastIndex = IndexWidth'(FrameBits - 1);

   logic [WordWidth-1:0]    reciprocal_ff;
   logic                    multiplier_on_ff;
   logic                    powered_down_ff;
   logic                    invert_lines_ff;

   logic                    s1_valid_ff;
   logic [FreqWidth-1:0]    freq_ff;
   logic                    s2_valid_ff;
   logic [WordWidth-1:0]    word_ff;
   logic                    out_valid_ff;
   logic [FrameBits-1:0]    frame_ff;
   logic [WordWidth-1:0]    out_word_ff;
   logic [IndexWidth-1:0]   index_ff;

   logic [ProductWidth-1:0] product;
   logic [WordWidth-1:0]    word_in;
   logic                    last_bit;
   logic                    out_done;
   logic                    out_free;
   logic                    s2_free;
   logic                    s1_free;
   logic                    s2_move;
   logic                    s1_move;
   logic                    req_take;
   logic                    rsp_take;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         reciprocal_ff    <= ReciprocalReset;
         multiplier_on_ff <= 1'b1;
         powered_down_ff  <= 1'b0;
         invert_lines_ff  <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RECIPROCAL:    reciprocal_ff    <= csr_data[WordWidth-1:0];
            CSR_MULTIPLIER_ON: multiplier_on_ff <= csr_data[0];
            CSR_POWERED_DOWN:  powered_down_ff  <= csr_data[0];
            CSR_INVERT_LINES:  invert_lines_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign rsp_take = rsp_valid && rsp_ready;
   assign last_bit = (index_ff == LastIndex);
   assign out_done = rsp_take && last_bit;
   assign out_free = !out_valid_ff || out_done;
   assign s2_move  = s2_valid_ff && out_free;
   assign s2_free  = !s2_valid_ff || out_free;
   assign s1_move  = s1_valid_ff && s2_free;
   assign s1_free  = !s1_valid_ff || s2_free;
   assign req_ready = s1_free;
   assign req_take = req_valid && req_ready;

   assign product = ProductWidth'(freq_ff) * ProductWidth'(reciprocal_ff);
   assign word_in = product[WordLsb +: WordWidth];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         freq_ff <= req_freq_hz;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_move) begin
         s2_valid_ff <= 1'b1;
      end else if (s2_move) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         word_ff <= word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s2_move) begin
         out_valid_ff <= 1'b1;
      end else if (out_done) begin
         out_valid_ff <= 1'b0;
      end
   end

   // load a new frame, or advance one bit per taken item
   always_ff @(posedge clock) begin
      if (s2_move) begin
         frame_ff    <= {control_byte(powered_down_ff, multiplier_on_ff), word_ff};
         out_word_ff <= word_ff;
         index_ff    <= '0;
      end else if (rsp_take) begin
         frame_ff    <= frame_ff >> 1;
         index_ff    <= index_ff + IndexWidth'(1);
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_line_level  = frame_ff[0] ^ invert_lines_ff;
   assign rsp_bit_index   = index_ff;
   assign rsp_tuning_word = out_word_ff;
   assign rsp_latch       = last_bit;

endmodule
